// ===== hw/rtl/stbs_pkg.sv =====
// Package for the sorted-table binary search block.
// Shared constants and controller/datapath interface structs; no dependencies.
package stbs_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = IDX_W + 1;
    localparam int BND_W       = LEN_W + 1;   // signed search bound, holds -1
    localparam int DATA_W      = 32;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic write;      // store entry_value at entry_index
        logic load;       // latch key, init bounds
        logic probe;      // read table at midpoint
        logic update;     // narrow bounds after a miss compare
        logic emit_hit;   // result: found at midpoint
        logic emit_miss;  // result: not found
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic crossed;    // left > right
        logic hit;        // probed entry equals key
    } t_status;

endpackage

// ===== hw/rtl/stbs_ctrl.sv =====
// Search sequencer for the sorted-table binary search block.
// Depends on stbs_pkg (t_cmd, t_status, FUNC_* codes).
module stbs_ctrl
    import stbs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  logic    i_func,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    busy
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROBE = 2'd1;
    localparam logic [1:0] ST_CMP   = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_func == FUNC_SEARCH) begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_PROBE;
                    end else begin
                        o_cmd.write = 1'b1;
                    end
                end
            end
            ST_PROBE: begin
                if (i_status.crossed) begin
                    o_cmd.emit_miss = 1'b1;
                    n_state         = ST_IDLE;
                end else begin
                    o_cmd.probe = 1'b1;
                    n_state     = ST_CMP;
                end
            end
            ST_CMP: begin
                if (i_status.hit) begin
                    o_cmd.emit_hit = 1'b1;
                    n_state        = ST_IDLE;
                end else begin
                    o_cmd.update = 1'b1;
                    n_state      = ST_PROBE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy = (r_state != ST_IDLE);

endmodule

// ===== hw/rtl/stbs_dpath.sv =====
// Datapath for the sorted-table binary search block: table memory, length
// register, search bounds, compare and result registers. Depends on stbs_pkg.
module stbs_dpath
    import stbs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [LEN_W-1:0]         i_cfg_data,
    input  logic [IDX_W-1:0]         i_entry_index,
    input  logic signed [DATA_W-1:0] i_entry_value,
    input  logic signed [DATA_W-1:0] i_key,
    input  t_cmd                     i_cmd,
    output t_status                  o_status,
    output logic                     o_valid,
    output logic                     o_found,
    output logic [IDX_W-1:0]         o_position
);

    logic [DATA_W-1:0] r_mem [TABLE_DEPTH];

    logic [LEN_W-1:0]         r_len;
    logic signed [DATA_W-1:0] r_key;
    logic signed [DATA_W-1:0] r_rdata;
    logic signed [BND_W-1:0]  r_left;
    logic signed [BND_W-1:0]  r_right;
    logic [IDX_W-1:0]         r_mid;
    logic                     r_valid;
    logic                     r_found;
    logic [IDX_W-1:0]         r_position;

    logic [LEN_W-1:0] len_eff;
    logic [BND_W-1:0] bound_sum;
    logic [IDX_W-1:0] mid;

    // lengths above the depth search the whole table
    assign len_eff   = (r_len > LEN_W'(TABLE_DEPTH)) ? LEN_W'(TABLE_DEPTH) : r_len;
    // only used while bounds are nonnegative and uncrossed
    assign bound_sum = BND_W'(r_left) + BND_W'(r_right);
    assign mid       = bound_sum[IDX_W:1];

    assign o_status.crossed = (r_left > r_right);
    assign o_status.hit     = (r_rdata == r_key);

    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_mem[i_entry_index] <= i_entry_value;
        end
        if (i_cmd.probe) begin
            r_rdata <= $signed(r_mem[mid]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key   <= i_key;
            r_left  <= '0;
            r_right <= $signed(BND_W'(len_eff)) - $signed(BND_W'(1));
        end
        if (i_cmd.probe) begin
            r_mid <= mid;
        end
        if (i_cmd.update) begin
            if (r_rdata < r_key) begin
                r_left  <= $signed(BND_W'(r_mid)) + $signed(BND_W'(1));
            end else begin
                r_right <= $signed(BND_W'(r_mid)) - $signed(BND_W'(1));
            end
        end
        if (i_cmd.emit_hit) begin
            r_found    <= 1'b1;
            r_position <= r_mid;
        end else if (i_cmd.emit_miss) begin
            r_found    <= 1'b0;
            r_position <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_len <= i_cfg_data;
            end
            r_valid <= i_cmd.emit_hit | i_cmd.emit_miss;
        end
    end

    assign o_valid    = r_valid;
    assign o_found    = r_found;
    assign o_position = r_position;

endmodule

// ===== hw/rtl/sorted_table_binary_search.sv =====
// Top level of the sorted-table binary search block.
// Instantiates stbs_ctrl and stbs_dpath; depends on stbs_pkg.
//
// Input words are taken at a rising edge with start high and busy low.
// i_func selects the operation: a write word stores i_entry_value at
// i_entry_index and gives no result; a search word looks up i_key over the
// first table_length entries (ascending values expected). table_length is
// written through i_cfg_we/i_cfg_data; the user must write it only while
// idle, which the block does not enforce; values above the table depth
// search the whole table. A write word completes in its accept cycle and
// busy stays low. A search repeats a probe (registered table read) and a
// compare with bound update; a miss ends in the probe state, which sees the
// crossed bounds. 32 entries need at most 6 probes, and busy drops in the
// cycle the result is shown.
// o_valid is high for exactly one cycle with o_found/o_position; a miss
// gives o_found = 0 and o_position = 0. The receiver cannot stall.
// i_rst_n (synchronous, active low) idles the sequencer and clears
// table_length; the table is not cleared and must be written before use.
module sorted_table_binary_search
    import stbs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_func,
    input  logic [IDX_W-1:0]         i_entry_index,
    input  logic signed [DATA_W-1:0] i_entry_value,
    input  logic signed [DATA_W-1:0] i_key,
    input  logic                     i_cfg_we,
    input  logic [LEN_W-1:0]         i_cfg_data,
    output logic                     o_valid,
    output logic                     o_found,
    output logic [IDX_W-1:0]         o_position
);

    t_cmd    cmd;
    t_status status;

    // sequencer: one search at a time, writes done in idle
    stbs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_func   (i_func),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    // table memory, bounds, compare and result word
    stbs_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_key         (i_key),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_valid       (o_valid),
        .o_found       (o_found),
        .o_position    (o_position)
    );

endmodule
